[hw/rtl/meh_pkg.sv]
// shared types and constants for the midi event humanizer
// no dependencies; used by meh_div and midi_event_humanizer
`timescale 1ns / 1ps

package meh_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_SEED      = 3'd0;
    localparam logic [2:0] CFG_JITTER    = 3'd1;
    localparam logic [2:0] CFG_VEL_RANGE = 3'd2;
    localparam logic [2:0] CFG_SWING     = 3'd3;
    localparam logic [2:0] CFG_SNAP_EN   = 3'd4;
    localparam logic [2:0] CFG_GRID      = 3'd5;
    localparam logic [2:0] CFG_POST      = 3'd6;

    // post-shift styles
    localparam logic [1:0] POST_NONE   = 2'd0;
    localparam logic [1:0] POST_LAID   = 2'd1;
    localparam logic [1:0] POST_PUSHED = 2'd2;

    // mt19937-64
    localparam int          TW_N      = 312;
    localparam int          TW_M      = 156;
    localparam int          TW_AW     = 9;
    localparam logic [63:0] TW_MATRIX = 64'hB502_6F5A_A966_19E9;
    localparam logic [63:0] TW_UPPER  = 64'hFFFF_FFFF_8000_0000;
    localparam logic [63:0] TW_LOWER  = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] TW_SEED_MUL = 64'h5851_F42D_4C95_7F2D;
    localparam logic [63:0] TMP_B     = 64'h5555_5555_5555_5555;
    localparam logic [63:0] TMP_C     = 64'h71D6_7FFF_EDA6_0000;
    localparam logic [63:0] TMP_D     = 64'hFFF7_EEE0_0000_0000;

    // tick arithmetic
    localparam int TICK_W = 35;
    typedef logic signed [TICK_W-1:0] t_tick;
    localparam t_tick TICK_MAX = 35'sh0_7FFF_FFFF;

    // velocity / 10 as multiply by reciprocal, exact below 16384
    localparam logic [12:0] RECIP_10 = 13'd6554;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [15:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quot;
        logic [15:0] rem;
    } t_div_rsp;

endpackage

[hw/rtl/meh_ram.sv]
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`timescale 1ns / 1ps

module meh_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 312
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/meh_div.sv]
// bit-serial restoring divider, 64-bit dividend by 16-bit divisor, one bit a cycle
// depends on meh_pkg
`timescale 1ns / 1ps

module meh_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  meh_pkg::t_div_req i_req,
    output meh_pkg::t_div_rsp o_rsp
);

    import meh_pkg::*;

    logic [63:0] r_q;
    logic [15:0] r_r;
    logic [15:0] r_d;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [16:0] w_t;
    logic        w_ge;

    assign w_t  = {r_r, r_q[63]};
    assign w_ge = w_t >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q <= i_req.dividend;
            r_r <= '0;
            r_d <= i_req.divisor;
        end else if (r_busy) begin
            r_q <= {r_q[62:0], w_ge};
            r_r <= w_ge ? 16'(w_t - {1'b0, r_d}) : w_t[15:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
    assign o_rsp.rem  = r_r;

endmodule

[hw/rtl/midi_event_humanizer.sv]
// midi event humanizer top level: sequencer, twister state ram, tick and velocity datapath
// depends on meh_pkg, meh_ram, meh_div
//
//  channel   dir  handshake               payload
//  in        in   i_in_valid/o_in_stall   i_batch_start i_on_tick i_off_tick i_note_velocity
//  out       out  o_out_valid/i_out_stall o_new_on_tick o_new_off_tick o_new_velocity
//  cfg       in   i_cfg_valid/o_cfg_ready i_cfg_index i_cfg_data
//
// one request at a time; the serial divider sets the pace: two divisions per request
// with no snap, four with snap enabled (swing test runs in S_SWING and S_SWINGW)
// a batch start adds seeding, a 64-bit multiply split in three 32x32 products per word
// every 156th request adds a ram refill (states S_RFA to S_RFD for each word)
// reset is synchronous; the twister ram is undefined until the first batch start
// a finished result sits in the output register while the next request is taken
`timescale 1ns / 1ps

module midi_event_humanizer #(
    parameter int PULSES_PER_QUARTER = 480
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_batch_start,
    input  logic [30:0] i_on_tick,
    input  logic [30:0] i_off_tick,
    input  logic [6:0]  i_note_velocity,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [30:0] o_new_on_tick,
    output logic [30:0] o_new_off_tick,
    output logic [6:0]  o_new_velocity,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    import meh_pkg::*;

    localparam logic [15:0] PPQ      = 16'(PULSES_PER_QUARTER);
    localparam logic [15:0] PPQ_HALF = 16'(PULSES_PER_QUARTER / 2);

    // on tick / ppq by reciprocal multiply, exact for 31-bit ticks
    localparam int          SW_SHIFT = 31 + $clog2(PULSES_PER_QUARTER);
    localparam logic [31:0] SW_RECIP = 32'(((64'd1 << SW_SHIFT) +
                                            64'(PULSES_PER_QUARTER - 1)) /
                                           64'(PULSES_PER_QUARTER));

    typedef enum logic [17:0] {
        S_IDLE   = 18'h00001,
        S_SEED   = 18'h00002,
        S_SMUL   = 18'h00004,
        S_SWR    = 18'h00008,
        S_SWING  = 18'h00010,
        S_SWINGW = 18'h00020,
        S_DRAW   = 18'h00040,
        S_DRAWD  = 18'h00080,
        S_DIVW   = 18'h00100,
        S_RFA    = 18'h00200,
        S_RFB    = 18'h00400,
        S_RFC    = 18'h00800,
        S_RFD    = 18'h01000,
        S_SNAP   = 18'h02000,
        S_SNAPW  = 18'h04000,
        S_SFIX   = 18'h08000,
        S_POST   = 18'h10000,
        S_SAT    = 18'h20000
    } t_state;

    t_state r_state;

    // configuration
    logic [63:0] r_seed;
    logic [9:0]  r_jit;
    logic [6:0]  r_vrng;
    logic [11:0] r_swing;
    logic        r_snap_en;
    logic [15:0] r_grid;
    logic [1:0]  r_post;

    // working registers
    t_tick          r_on;
    t_tick          r_off;
    logic [6:0]     r_vel;
    logic [8:0]     r_pos;
    logic [TW_AW-1:0] r_idx;
    logic [63:0]    r_p;
    logic [63:0]    r_acc;
    logic [1:0]     r_mcnt;
    logic [63:0]    r_x;
    logic [63:0]    r_y;
    logic           r_phase;
    logic           r_sel;
    logic           r_out_valid;
    logic [30:0]    r_out_on;
    logic [30:0]    r_out_off;
    logic [6:0]     r_out_vel;

    // ram
    logic             w_we;
    logic [TW_AW-1:0] w_waddr;
    logic [63:0]      w_wdata;
    logic [TW_AW-1:0] w_raddr;
    logic [63:0]      w_rdata;

    t_div_req w_req;
    t_div_rsp w_rsp;

    meh_ram #(.WIDTH(64), .DEPTH(TW_N)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    meh_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // seeding multiply, low 64 bits split in three 32x32 products
    logic [63:0] w_sx;
    logic [31:0] w_ma;
    logic [31:0] w_mb;
    logic [63:0] w_prod;
    logic [63:0] w_seedw;

    assign w_sx = r_p ^ (r_p >> 62);
    always_comb begin
        case (r_mcnt)
            2'd0: begin
                w_ma = TW_SEED_MUL[31:0];
                w_mb = w_sx[31:0];
            end
            2'd1: begin
                w_ma = TW_SEED_MUL[63:32];
                w_mb = w_sx[31:0];
            end
            default: begin
                w_ma = TW_SEED_MUL[31:0];
                w_mb = w_sx[63:32];
            end
        endcase
    end
    assign w_prod  = {32'd0, w_ma} * {32'd0, w_mb};
    assign w_seedw = r_acc + {55'd0, r_idx};

    // swing test: remainder of on tick by ppq
    logic [62:0] w_sw_prod;
    logic [63:0] w_sw_qfull;
    logic [30:0] w_sw_qm;
    logic [30:0] w_sw_rem;
    assign w_sw_prod  = 63'(r_on[30:0]) * 63'(SW_RECIP);
    assign w_sw_qfull = r_acc >> SW_SHIFT;
    assign w_sw_qm    = w_sw_qfull[30:0] * 31'(PPQ);
    assign w_sw_rem   = r_on[30:0] - r_acc[30:0];

    // refill twist
    logic [63:0] w_tx;
    logic [63:0] w_xa;
    logic [63:0] w_twist;
    assign w_tx    = (r_x & TW_UPPER) | (r_y & TW_LOWER);
    assign w_xa    = (w_tx >> 1) ^ (w_tx[0] ? TW_MATRIX : 64'd0);
    assign w_twist = w_rdata ^ w_xa;

    // tempering
    logic [63:0] w_t1;
    logic [63:0] w_t2;
    logic [63:0] w_t3;
    logic [63:0] w_temp;
    assign w_t1   = w_rdata ^ ((w_rdata >> 29) & TMP_B);
    assign w_t2   = w_t1 ^ ((w_t1 << 17) & TMP_C);
    assign w_t3   = w_t2 ^ ((w_t2 << 37) & TMP_D);
    assign w_temp = w_t3 ^ (w_t3 >> 43);

    logic [TW_AW-1:0] w_idx_p1;
    logic [TW_AW-1:0] w_idx_pm;
    assign w_idx_p1 = (r_idx == TW_AW'(TW_N - 1)) ? '0 : r_idx + TW_AW'(1);
    assign w_idx_pm = (r_idx < TW_AW'(TW_M)) ? r_idx + TW_AW'(TW_M) : r_idx - TW_AW'(TW_M);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = w_twist;
        w_raddr = r_idx;
        case (r_state)
            S_SEED: begin
                w_we    = 1'b1;
                w_waddr = '0;
                w_wdata = r_seed;
            end
            S_SWR: begin
                w_we    = 1'b1;
                w_wdata = w_seedw;
            end
            S_RFD: begin
                w_we = 1'b1;
            end
            S_DRAW:  w_raddr = r_pos[TW_AW-1:0];
            S_RFB:   w_raddr = w_idx_p1;
            S_RFC:   w_raddr = w_idx_pm;
            default: w_raddr = r_idx;
        endcase
    end

    // divider requests
    t_tick w_snap_src;
    assign w_snap_src = r_sel ? r_off : r_on;

    always_comb begin
        w_req.start    = 1'b0;
        w_req.dividend = {33'd0, r_on[30:0]};
        w_req.divisor  = r_grid;
        case (r_state)
            S_DRAWD: begin
                w_req.start    = 1'b1;
                w_req.dividend = w_temp;
                w_req.divisor  = r_phase ? {8'd0, r_vrng, 1'b1} : {5'd0, r_jit, 1'b1};
            end
            S_SNAP: begin
                w_req.start    = 1'b1;
                w_req.dividend = {29'd0, w_snap_src} + {49'd0, r_grid[15:1]};
                w_req.divisor  = r_grid;
            end
            default: w_req.start = 1'b0;
        endcase
    end

    // jitter
    logic signed [11:0] w_j;
    t_tick w_non;
    t_tick w_noff;
    t_tick w_jon;
    t_tick w_joff;
    t_tick w_joff2;
    assign w_j     = $signed({1'b0, w_rsp.rem[10:0]}) - $signed({2'b0, r_jit});
    assign w_non   = r_on + TICK_W'(w_j);
    assign w_noff  = r_off + TICK_W'(w_j);
    assign w_jon   = (w_non < 0) ? '0 : w_non;
    assign w_joff  = (w_noff > w_non + 35'sd1) ? w_noff : w_non + 35'sd1;
    assign w_joff2 = (w_joff < 0) ? '0 : w_joff;

    // velocity delta
    logic signed [8:0] w_d;
    logic signed [9:0] w_vs;
    logic [6:0]        w_vclamp;
    assign w_d  = $signed({1'b0, w_rsp.rem[7:0]}) - $signed({2'b0, r_vrng});
    assign w_vs = $signed({3'b0, r_vel}) + 10'(w_d);
    assign w_vclamp = (w_vs < 10'sd1) ? 7'd1 : (w_vs > 10'sd127) ? 7'd127 : w_vs[6:0];

    // snap product
    logic [48:0] w_sprod;
    t_tick       w_snapped;
    assign w_sprod   = 49'(w_rsp.quot[32:0]) * 49'(r_grid);
    assign w_snapped = $signed({1'b0, w_sprod[33:0]});

    // post-shift
    logic              w_post_on;
    logic signed [4:0] w_sh;
    t_tick             w_pon;
    t_tick             w_pon2;
    t_tick             w_poff;
    t_tick             w_poff2;
    logic [10:0]       w_vm;
    logic [23:0]       w_vq;
    logic [6:0]        w_vpost;

    assign w_post_on = (r_post == POST_LAID) || (r_post == POST_PUSHED);
    assign w_sh      = (r_post == POST_LAID) ? 5'sd10 : -5'sd5;
    assign w_pon     = r_on + TICK_W'(w_sh);
    assign w_pon2    = (w_pon < 0) ? '0 : w_pon;
    assign w_poff    = r_off + TICK_W'(w_sh);
    assign w_poff2   = (w_poff > w_pon2 + 35'sd1) ? w_poff : w_pon2 + 35'sd1;
    assign w_vm      = (r_post == POST_LAID)
                     ? ({1'b0, r_vel, 3'b0} + {4'd0, r_vel})
                     : ({1'b0, r_vel, 3'b0} + {3'd0, r_vel, 1'b0} + {4'd0, r_vel});
    assign w_vq      = 24'(w_vm) * 24'(RECIP_10);

    always_comb begin
        case (r_post)
            POST_LAID:   w_vpost = (w_vq[23:16] == 8'd0) ? 7'd1 : w_vq[22:16];
            POST_PUSHED: w_vpost = (w_vq[23:16] > 8'd127) ? 7'd127 : w_vq[22:16];
            default:     w_vpost = r_vel;
        endcase
    end

    // output saturation
    t_tick w_son;
    t_tick w_soff;
    t_tick w_soff2;
    assign w_son   = (r_on > TICK_MAX - 35'sd1) ? TICK_MAX - 35'sd1 : r_on;
    assign w_soff  = (r_off > TICK_MAX) ? TICK_MAX : r_off;
    assign w_soff2 = (w_soff <= w_son) ? w_son + 35'sd1 : w_soff;

    logic w_load;
    assign w_load = (r_state == S_SAT) && (!r_out_valid || !i_out_stall);

    // configuration port
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed    <= '0;
            r_jit     <= '0;
            r_vrng    <= '0;
            r_swing   <= '0;
            r_snap_en <= 1'b0;
            r_grid    <= 16'd120;
            r_post    <= POST_NONE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SEED:      r_seed    <= i_cfg_data;
                CFG_JITTER:    r_jit     <= i_cfg_data[9:0];
                CFG_VEL_RANGE: r_vrng    <= i_cfg_data[6:0];
                CFG_SWING:     r_swing   <= i_cfg_data[11:0];
                CFG_SNAP_EN:   r_snap_en <= i_cfg_data[0];
                CFG_GRID:      r_grid    <= i_cfg_data[15:0];
                CFG_POST:      r_post    <= i_cfg_data[1:0];
                default:       r_seed    <= r_seed;
            endcase
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= 9'(TW_N);
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_on    <= $signed({4'd0, i_on_tick});
                        r_off   <= $signed({4'd0, i_off_tick});
                        r_vel   <= i_note_velocity;
                        r_phase <= 1'b0;
                        r_state <= i_batch_start ? S_SEED : S_SWING;
                    end
                end
                S_SEED: begin
                    r_p     <= r_seed;
                    r_idx   <= TW_AW'(1);
                    r_mcnt  <= 2'd0;
                    r_state <= S_SMUL;
                end
                S_SMUL: begin
                    if (r_mcnt == 2'd0) begin
                        r_acc <= w_prod;
                    end else begin
                        r_acc <= r_acc + {w_prod[31:0], 32'd0};
                    end
                    r_mcnt <= r_mcnt + 2'd1;
                    if (r_mcnt == 2'd2) begin
                        r_state <= S_SWR;
                    end
                end
                S_SWR: begin
                    r_p    <= w_seedw;
                    r_mcnt <= 2'd0;
                    if (r_idx == TW_AW'(TW_N - 1)) begin
                        r_pos   <= 9'(TW_N);
                        r_state <= S_SWING;
                    end else begin
                        r_idx   <= r_idx + TW_AW'(1);
                        r_state <= S_SMUL;
                    end
                end
                S_SWING: begin
                    r_acc   <= {1'b0, w_sw_prod};
                    r_mcnt  <= 2'd0;
                    r_state <= S_SWINGW;
                end
                S_SWINGW: begin
                    if (r_mcnt == 2'd0) begin
                        r_acc  <= {33'd0, w_sw_qm};
                        r_mcnt <= 2'd1;
                    end else begin
                        // off-beat eighth
                        if (r_swing != 12'd0 && w_sw_rem == {15'd0, PPQ_HALF}) begin
                            r_on  <= r_on + $signed({23'd0, r_swing});
                            r_off <= r_off + $signed({23'd0, r_swing});
                        end
                        r_state <= S_DRAW;
                    end
                end
                S_DRAW: begin
                    if (r_pos >= 9'(TW_N)) begin
                        r_idx   <= '0;
                        r_state <= S_RFA;
                    end else begin
                        r_state <= S_DRAWD;
                    end
                end
                S_DRAWD: begin
                    r_pos   <= r_pos + 9'd1;
                    r_state <= S_DIVW;
                end
                S_DIVW: begin
                    if (w_rsp.done) begin
                        if (!r_phase) begin
                            if (w_j != 12'sd0) begin
                                r_on  <= w_jon;
                                r_off <= w_joff2;
                            end
                            r_phase <= 1'b1;
                            r_state <= S_DRAW;
                        end else begin
                            r_vel <= w_vclamp;
                            if (r_off <= r_on) begin
                                r_off <= r_on + 35'sd1;
                            end
                            r_sel   <= 1'b0;
                            r_state <= (r_snap_en && r_grid != 16'd0) ? S_SNAP : S_POST;
                        end
                    end
                end
                S_RFA: begin
                    r_state <= S_RFB;
                end
                S_RFB: begin
                    r_x     <= w_rdata;
                    r_state <= S_RFC;
                end
                S_RFC: begin
                    r_y     <= w_rdata;
                    r_state <= S_RFD;
                end
                S_RFD: begin
                    if (r_idx == TW_AW'(TW_N - 1)) begin
                        r_pos   <= '0;
                        r_state <= S_DRAW;
                    end else begin
                        r_idx   <= r_idx + TW_AW'(1);
                        r_state <= S_RFA;
                    end
                end
                S_SNAP: begin
                    r_state <= S_SNAPW;
                end
                S_SNAPW: begin
                    if (w_rsp.done) begin
                        if (r_sel) begin
                            r_off   <= w_snapped;
                            r_state <= S_SFIX;
                        end else begin
                            r_on    <= w_snapped;
                            r_sel   <= 1'b1;
                            r_state <= S_SNAP;
                        end
                    end
                end
                S_SFIX: begin
                    if (r_off <= r_on) begin
                        r_off <= r_on + $signed({19'd0, r_grid});
                    end
                    r_state <= S_POST;
                end
                S_POST: begin
                    if (w_post_on) begin
                        r_on  <= w_pon2;
                        r_off <= w_poff2;
                    end
                    r_vel   <= w_vpost;
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    if (w_load) begin
                        r_out_on  <= w_son[30:0];
                        r_out_off <= w_soff2[30:0];
                        r_out_vel <= r_vel;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_new_on_tick  = r_out_on;
    assign o_new_off_tick = r_out_off;
    assign o_new_velocity = r_out_vel;

endmodule
